[design/deq_pkg.sv]
// deq_pkg: command and status codes plus the response control struct
// shared by the deque control logic, the top level and the checker.
// No dependencies.
package deq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // Control info that travels with a request into the response stage.
  typedef struct packed {
    logic    rd;      // result takes the RAM read data
    status_t status;
  } resp_ctl_t;

endpackage

[design/deq_ram.sv]
// deq_ram: single-port-write, single-port-read storage for the ring,
// read data registered. No package dependency.
module deq_ram #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Holds its value until the next read request.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/deq_ctrl.sv]
// deq_ctrl: front/back pointers and occupancy of the ring, decodes each
// request into a RAM write or read. Depends on deq_pkg.
module deq_ctrl
  import deq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic [2:0]                 cmd,
  input  logic [DATA_WIDTH-1:0]      data,
  output logic                       we,
  output logic [$clog2(DEPTH)-1:0]   waddr,
  output logic [DATA_WIDTH-1:0]      wdata,
  output logic                       re,
  output logic [$clog2(DEPTH)-1:0]   raddr,
  output resp_ctl_t                  ctl,
  output logic [$clog2(DEPTH+1)-1:0] fill
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] back_r, back_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic          full, empty;
  logic          wr_req, rd_req;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

  assign full  = (occ_r == CW'(DEPTH));
  assign empty = (occ_r == '0);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    occ_nxt    = occ_r;
    wr_req     = 1'b0;
    waddr      = back_r;
    rd_req     = 1'b0;
    raddr      = front_r;
    ctl.rd     = 1'b0;
    ctl.status = ST_OK;
    unique case (cmd_t'(cmd))
      CMD_PUSH_BACK: begin
        wr_req   = 1'b1;
        waddr    = back_r;
        back_nxt = idx_next(back_r);
        if (full) begin
          // oldest front entry is dropped
          front_nxt  = idx_next(front_r);
          ctl.status = ST_OVER;
        end else begin
          occ_nxt = occ_r + CW'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        wr_req    = 1'b1;
        waddr     = idx_prev(front_r);
        front_nxt = idx_prev(front_r);
        if (full) begin
          // newest back entry is replaced
          back_nxt   = idx_prev(front_r);
          ctl.status = ST_OVER;
        end else begin
          occ_nxt = occ_r + CW'(1);
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          rd_req = 1'b1;
          raddr  = front_r;
          ctl.rd = 1'b1;
          if (cmd_t'(cmd) == CMD_POP_FRONT) begin
            front_nxt = idx_next(front_r);
            occ_nxt   = occ_r - CW'(1);
          end
        end
      end
      CMD_POP_BACK, CMD_PEEK_BACK: begin
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          rd_req = 1'b1;
          raddr  = idx_prev(back_r);
          ctl.rd = 1'b1;
          if (cmd_t'(cmd) == CMD_POP_BACK) begin
            back_nxt = idx_prev(back_r);
            occ_nxt  = occ_r - CW'(1);
          end
        end
      end
      default: begin
        // unused codes: no change, status ok
      end
    endcase
  end

  assign we    = acc && wr_req;
  assign re    = acc && rd_req;
  assign wdata = data;
  assign fill  = occ_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      occ_r   <= '0;
    end else if (acc) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      occ_r   <= occ_nxt;
    end
  end

endmodule

[design/double_ended_ring_buffer.sv]
// double_ended_ring_buffer: top level of the double-ended ring queue.
// Instantiates deq_ctrl and deq_ram; depends on deq_pkg.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   request | in_valid, in_stall, in_cmd, in_data_in       | in
//   result  | out_valid, out_stall, out_data_out,          | out
//           | out_status, out_fill_count                   |
//
// One request per cycle sustained while out_stall is low. The edge that
// takes a request updates the pointers, reads the RAM and loads the
// response stage; the result then moves into the output register.
// The RAM read port sets the latency: pops and peeks need the registered
// read data before the result can be formed.
// rst_n is synchronous, active low; it clears pointers, occupancy and
// valids. Storage contents are not cleared.
// out_stall holds the output register; the response stage behind it holds
// one more request, after which in_stall is raised.
module double_ended_ring_buffer
  import deq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_cmd,
  input  logic [DATA_WIDTH-1:0]      in_data_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [DATA_WIDTH-1:0]      out_data_out,
  output logic [1:0]                 out_status,
  output logic [$clog2(DEPTH+1)-1:0] out_fill_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                  acc;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  resp_ctl_t             ctl;
  logic [CW-1:0]         fill;

  // response stage: waits for the registered RAM read data
  logic                  rsp_valid_r;
  resp_ctl_t             rsp_ctl_r;
  logic [CW-1:0]         rsp_fill_r;
  logic                  rsp_move;

  // output register
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic [1:0]            out_status_r;
  logic [CW-1:0]         out_fill_r;

  // Response moves on when the output register is empty or being drained.
  assign rsp_move = rsp_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = rsp_valid_r && !rsp_move;
  assign acc      = in_valid && !in_stall;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .cmd   (in_cmd),
    .data  (in_data_in),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .ctl   (ctl),
    .fill  (fill)
  );

  // A write lands at the edge of its request, so a read issued by any
  // later request already sees it; no forwarding is needed.
  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_valid_r <= 1'b0;
    end else if (acc) begin
      rsp_valid_r <= 1'b1;
    end else if (rsp_move) begin
      rsp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp_ctl_r  <= ctl;
      rsp_fill_r <= fill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // rdata only changes on a new read, and a read is only issued when the
  // response stage is free or moving, so it is stable while we wait.
  always_ff @(posedge clk) begin
    if (rsp_move) begin
      out_data_r   <= rsp_ctl_r.rd ? rdata : '0;
      out_status_r <= rsp_ctl_r.status;
      out_fill_r   <= rsp_fill_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

endmodule

[design/deq_chk.sv]
// deq_chk: port-level checker for double_ended_ring_buffer, plus its bind.
// Depends on deq_pkg.
module deq_chk
  import deq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [2:0]                 in_cmd,
  input logic [DATA_WIDTH-1:0]      in_data_in,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [DATA_WIDTH-1:0]      out_data_out,
  input logic [1:0]                 out_status,
  input logic [$clog2(DEPTH+1)-1:0] out_fill_count
);

  localparam int CW = $clog2(DEPTH + 1);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_data_out == '0 && out_fill_count == '0)
    else $error("empty status with data or nonzero fill");

  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVER |-> out_fill_count == CW'(DEPTH))
    else $error("overwrite status while not full");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill_count <= CW'(DEPTH) && out_status != 2'd3)
    else $error("fill count or status out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_out) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind double_ended_ring_buffer deq_chk #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_deq_chk (.*);

[tb/tb_double_ended_ring_buffer.sv]
// tb_double_ended_ring_buffer: self-checking bench for the double-ended ring queue.
// Directed table plus biased random requests, each result checked against a local deque model.
// Depends on deq_pkg and double_ended_ring_buffer.
module tb_double_ended_ring_buffer;
  import deq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int FILL_W     = $clog2(DEPTH + 1);

  // Unused command codes: the block must answer OK with no state change.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int HANG_LIMIT     = 1000;  // cycles with no handshake on either side
  localparam int TAIL_CYCLES    = 8;     // covers the response stage and output register
  localparam int RAND_SEGMENTS  = 14;
  localparam int SEGMENT_ITEMS  = 125;
  localparam int MAX_MSG_LINES  = 40;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    status_t               status;
    logic [FILL_W-1:0]     fill;
  } deq_result_t;

  // One row of the directed table. Rows with reps > 1 repeat the command, data rising by one.
  // A typed expectation is only used on single rows.
  typedef struct {
    logic [2:0]            cmd;
    logic [DATA_WIDTH-1:0] data;
    int                    reps;
    bit                    typed;
    logic [DATA_WIDTH-1:0] exp_data;
    status_t               exp_status;
    logic [FILL_W-1:0]     exp_fill;
  } dir_row_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [2:0]            in_cmd         = '0;
  logic [DATA_WIDTH-1:0] in_data_in     = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [DATA_WIDTH-1:0] out_data_out;
  logic [1:0]            out_status;
  logic [FILL_W-1:0]     out_fill_count;

  always #4 clk = ~clk;

  double_ended_ring_buffer #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  // ---------------------------------------------------------------------
  // Deque model: ring of DEPTH words, back slot is the next push-back
  // target, front slot holds the oldest entry.
  // ---------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] ring_words [DEPTH];
  int                    ring_back  = 0;
  int                    ring_front = 0;
  int                    ring_count = 0;

  deq_result_t pending_results [$];  // expected results, oldest first
  int          error_count   = 0;
  int          result_index  = 0;
  bit          tx_quiet      = 1'b0;  // sender never idles
  bit          rx_quiet      = 1'b0;  // receiver never stalls

  function automatic int ring_next(int i);
    return (i + 1) % DEPTH;
  endfunction

  function automatic int ring_prev(int i);
    return (i + DEPTH - 1) % DEPTH;
  endfunction

  // Applies one request to the model and returns the result it should give.
  function automatic deq_result_t deque_apply(logic [2:0] cmd, logic [DATA_WIDTH-1:0] word);
    deq_result_t res;
    int          slot;
    res.data   = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_PUSH_BACK: begin
        // full: oldest front entry is dropped
        if (ring_count >= DEPTH) begin
          ring_front = ring_next(ring_front);
          res.status = ST_OVER;
        end else begin
          ring_count++;
        end
        ring_words[ring_back] = word;
        ring_back = ring_next(ring_back);
      end
      CMD_PUSH_FRONT: begin
        // full: the new front lands on the newest back entry
        ring_front = ring_prev(ring_front);
        ring_words[ring_front] = word;
        if (ring_count >= DEPTH) begin
          ring_back  = ring_front;
          res.status = ST_OVER;
        end else begin
          ring_count++;
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = ring_words[ring_front];
          if (cmd == CMD_POP_FRONT) begin
            ring_front = ring_next(ring_front);
            ring_count--;
          end
        end
      end
      CMD_POP_BACK, CMD_PEEK_BACK: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = ring_prev(ring_back);
          res.data = ring_words[slot];
          if (cmd == CMD_POP_BACK) begin
            ring_back = slot;
            ring_count--;
          end
        end
      end
      default: ;  // spare codes: no effect
    endcase
    res.fill = ring_count[FILL_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_WIDTH-1:0] got,
                                 logic [DATA_WIDTH-1:0] want);
    error_count++;
    if (error_count <= MAX_MSG_LINES)
      $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
               $realtime, result_index, what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Result side: check every accepted result, then draw the next stall.
  // Outputs are read at the edge, before this edge's updates land.
  // ---------------------------------------------------------------------
  int          stall_left = 0;
  deq_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, data", out_data_out, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_data_out !== want.data)
            report_mismatch("data_out", out_data_out, want.data);
          if (out_status !== want.status)
            report_mismatch("status", DATA_WIDTH'(out_status),
                            DATA_WIDTH'(want.status));
          if (out_fill_count !== want.fill)
            report_mismatch("fill_count", DATA_WIDTH'(out_fill_count),
                            DATA_WIDTH'(want.fill));
        end
        result_index++;
        stall_left = rx_quiet ? 0 : $urandom_range(0, 3);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Hang detector: any stretch with no handshake on either channel.
  int hang_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        hang_cycles = 0;
      end else begin
        hang_cycles++;
        if (hang_cycles >= HANG_LIMIT) begin
          $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
          $display("tb_double_ended_ring_buffer NOT OK");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Drives one request and holds it until taken. Called right after the
  // previous acceptance, so a zero gap keeps in_valid high without a dip.
  task automatic send_request(logic [2:0] cmd, logic [DATA_WIDTH-1:0] word,
                              bit typed, deq_result_t typed_res);
    int          gap;
    deq_result_t pred;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_data_in <= word;
    do @(posedge clk); while (in_stall);
    // taken at this edge
    pred = deque_apply(cmd, word);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // Sender pause: hold off until every outstanding result has drained.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [2:0] pick_cmd(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)
      return ($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
    if ($urandom_range(0, 99) < push_pct)
      return ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    case ($urandom_range(0, 3))
      0:       return CMD_POP_FRONT;
      1:       return CMD_POP_BACK;
      2:       return CMD_PEEK_FRONT;
      default: return CMD_PEEK_BACK;
    endcase
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Directed table: empty reads, spare codes, data extremes, filling to
  // full, overwrite from both ends, then a full drain past empty.
  dir_row_t dir_rows [] = '{
    '{CMD_POP_FRONT,  32'h0,        1,     1'b1, 32'h0,        ST_EMPTY, 5'd0},
    '{CMD_POP_BACK,   32'h0,        1,     1'b1, 32'h0,        ST_EMPTY, 5'd0},
    '{CMD_PEEK_FRONT, 32'h0,        1,     1'b1, 32'h0,        ST_EMPTY, 5'd0},
    '{CMD_PEEK_BACK,  32'h0,        1,     1'b1, 32'h0,        ST_EMPTY, 5'd0},
    '{CMD_SPARE_6,    32'hFFFFFFFF, 1,     1'b1, 32'h0,        ST_OK,    5'd0},
    '{CMD_SPARE_7,    32'h0,        1,     1'b1, 32'h0,        ST_OK,    5'd0},
    '{CMD_PUSH_BACK,  32'hFFFFFFFF, 1,     1'b1, 32'h0,        ST_OK,    5'd1},
    '{CMD_PUSH_FRONT, 32'h00000000, 1,     1'b1, 32'h0,        ST_OK,    5'd2},
    '{CMD_PEEK_FRONT, 32'h0,        1,     1'b1, 32'h00000000, ST_OK,    5'd2},
    '{CMD_PEEK_BACK,  32'h0,        1,     1'b1, 32'hFFFFFFFF, ST_OK,    5'd2},
    '{CMD_SPARE_7,    32'h0,        1,     1'b1, 32'h0,        ST_OK,    5'd2},
    '{CMD_POP_BACK,   32'h0,        1,     1'b1, 32'hFFFFFFFF, ST_OK,    5'd1},
    '{CMD_POP_FRONT,  32'h0,        1,     1'b1, 32'h00000000, ST_OK,    5'd0},
    '{CMD_PUSH_BACK,  32'hA5A50000, DEPTH, 1'b0, 32'h0,        ST_OK,    5'd0},
    '{CMD_PUSH_BACK,  32'h5A5A5A5A, 1,     1'b1, 32'h0,        ST_OVER,  5'd16},
    '{CMD_PUSH_FRONT, 32'h12345678, 1,     1'b1, 32'h0,        ST_OVER,  5'd16},
    '{CMD_PEEK_FRONT, 32'h0,        1,     1'b1, 32'h12345678, ST_OK,    5'd16},
    '{CMD_PEEK_BACK,  32'h0,        1,     1'b0, 32'h0,        ST_OK,    5'd0},
    '{CMD_POP_BACK,   32'h0,        1,     1'b0, 32'h0,        ST_OK,    5'd0},
    '{CMD_POP_FRONT,  32'h0,        DEPTH, 1'b0, 32'h0,        ST_OK,    5'd0},
    '{CMD_POP_BACK,   32'h0,        1,     1'b1, 32'h0,        ST_EMPTY, 5'd0},
    '{CMD_PUSH_FRONT, 32'hFFFFFFFF, 1,     1'b1, 32'h0,        ST_OK,    5'd1},
    '{CMD_PEEK_BACK,  32'h0,        1,     1'b1, 32'hFFFFFFFF, ST_OK,    5'd1}
  };

  // Per-segment push percentages: fill-heavy and drain-heavy phases push
  // the ring against both full and empty.
  int push_bias [5] = '{85, 15, 50, 65, 35};

  initial begin
    deq_result_t typed_res;
    int          push_pct;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling on either side for the first half.
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    foreach (dir_rows[r]) begin
      if (r == dir_rows.size() / 2) begin
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
      end
      typed_res.data   = dir_rows[r].exp_data;
      typed_res.status = dir_rows[r].exp_status;
      typed_res.fill   = dir_rows[r].exp_fill;
      for (int k = 0; k < dir_rows[r].reps; k++)
        send_request(dir_rows[r].cmd, dir_rows[r].data + k,
                     dir_rows[r].typed && dir_rows[r].reps == 1, typed_res);
    end

    wait_drained();

    // Random part: segments with their own push bias and idling mode.
    for (int s = 0; s < RAND_SEGMENTS; s++) begin
      push_pct = push_bias[$urandom_range(0, 4)];
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (s == RAND_SEGMENTS / 2)
        wait_drained();
      for (int i = 0; i < SEGMENT_ITEMS; i++)
        send_request(pick_cmd(push_pct), pick_word(), 1'b0, typed_res);
    end

    // Drain and let the pipeline settle so stray results still show up.
    rx_quiet = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_double_ended_ring_buffer OK");
    end else begin
      $display("tb_double_ended_ring_buffer NOT OK");
    end
    $finish;
  end

endmodule
